// ===== design/pve_pkg.sv =====
// Shared types and constants for the position and velocity estimator.
package pve_pkg;

    // Fraction bits of the time format; also the left shift of the delta.
    localparam int TIME_FRAC = 16;
    localparam int AXES      = 3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_GO,
        S_DIV_WAIT,
        S_MUL,
        S_ADD,
        S_SQ_GO,
        S_SQ_WAIT,
        S_OUT
    } t_state;

    typedef enum logic {
        M_DIV,
        M_SQRT
    } t_mode;

    typedef struct packed {
        logic  start;
        t_mode mode;
    } t_unit_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_stat;

endpackage

// ===== design/pve_if.sv =====
// Valid/ready channel interfaces for the estimator's request and result sides.
interface pve_in_if #(
    parameter int PW = 32,
    parameter int TW = 32
);
    logic                 valid;
    logic                 ready;
    logic                 index_invalid;
    logic                 entity_present;
    logic signed [PW-1:0] pos_x;
    logic signed [PW-1:0] pos_y;
    logic signed [PW-1:0] pos_z;
    logic signed [PW-1:0] origin_x;
    logic signed [PW-1:0] origin_y;
    logic signed [PW-1:0] origin_z;
    logic        [TW-1:0] now;

    modport source (
        output valid, index_invalid, entity_present, pos_x, pos_y, pos_z,
               origin_x, origin_y, origin_z, now,
        input  ready
    );
    modport sink (
        input  valid, index_invalid, entity_present, pos_x, pos_y, pos_z,
               origin_x, origin_y, origin_z, now,
        output ready
    );
endinterface

interface pve_out_if #(
    parameter int PW = 32
);
    logic                 valid;
    logic                 ready;
    logic signed [PW-1:0] out_x;
    logic signed [PW-1:0] out_y;
    logic signed [PW-1:0] out_z;
    logic signed [PW-1:0] vel_x;
    logic signed [PW-1:0] vel_y;
    logic signed [PW-1:0] vel_z;
    logic        [PW-1:0] speed;
    logic        [PW-1:0] speed_xy;

    modport source (
        output valid, out_x, out_y, out_z, vel_x, vel_y, vel_z, speed, speed_xy,
        input  ready
    );
    modport sink (
        input  valid, out_x, out_y, out_z, vel_x, vel_y, vel_z, speed, speed_xy,
        output ready
    );
endinterface

// ===== design/pve_iter.sv =====
// Shared shift/compare/subtract unit: restoring divider and digit-by-digit square root.
module pve_iter
    import pve_pkg::*;
#(
    parameter int PW = 32,
    parameter int TW = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_unit_ctl            i_ctl,
    input  logic [2*PW+1:0]      i_operand,
    input  logic [TW-1:0]        i_divisor,
    output t_unit_stat           o_stat,
    output logic [PW-1:0]        o_result
);

    localparam int XW   = 2*PW + 2;
    localparam int QW   = PW + 17;
    localparam int RW   = (TW + 1 > PW + 4) ? TW + 1 : PW + 4;
    localparam int CW   = $clog2(PW + 18);
    localparam int DIVN = PW + 17;
    localparam int SQN  = PW + 1;

    logic [XW-1:0] r_x;
    logic [RW-1:0] r_rem;
    logic [QW-1:0] r_q;
    logic [TW-1:0] r_div;
    logic [CW-1:0] r_cnt;
    t_mode         r_mode;
    logic          r_busy;
    logic          r_done;

    logic [RW-1:0] shifted;
    logic [RW-1:0] operand;
    logic [RW-1:0] diff;
    logic          ge;

    always_comb begin
        if (r_mode == M_DIV) begin
            shifted = {r_rem[RW-2:0], r_x[XW-1]};
            operand = RW'(r_div);
        end else begin
            shifted = {r_rem[RW-3:0], r_x[XW-1:XW-2]};
            operand = RW'({r_q[PW:0], 2'b01});
        end
        ge   = shifted >= operand;
        diff = shifted - operand;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= (i_ctl.mode == M_DIV) ? CW'(DIVN) : CW'(SQN);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_x    <= i_operand;
            r_div  <= i_divisor;
            r_mode <= i_ctl.mode;
            r_rem  <= '0;
            r_q    <= '0;
        end else if (r_busy) begin
            r_rem <= ge ? diff : shifted;
            r_q   <= {r_q[QW-2:0], ge};
            r_x   <= (r_mode == M_DIV) ? {r_x[XW-2:0], 1'b0} : {r_x[XW-3:0], 2'b00};
        end
    end

    // Quotients and roots that do not fit the position width saturate.
    assign o_result    = (|r_q[QW-1:PW]) ? {PW{1'b1}} : r_q[PW-1:0];
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

// ===== design/position_velocity_estimator.sv =====
// Top level of the finite-difference position and velocity estimator.
//
// Requests arrive on i_in (valid/ready) and results leave on o_out.
// A request with index_invalid set is taken and dropped. Otherwise the time
// since the previous request is formed; if it is not positive, only the
// stored time moves and no result follows. A positive step starts three
// divisions of the position change by the elapsed time on one shared
// shift-subtract unit, then two square roots on the same unit for the XY
// and 3D speeds, with one multiplier squaring each velocity magnitude, X and
// Y before the first root and Z between the roots. i_in.ready is high only
// while the sequencer is idle. The result sits in an output register until
// taken; a stalled receiver holds the sequencer before the register load,
// never dropping a result. Reset clears the stored time and position to
// zero and empties the output.
module position_velocity_estimator
    import pve_pkg::*;
#(
    parameter int POSITION_WIDTH = 32,
    parameter int TIME_WIDTH     = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pve_in_if.sink     i_in,
    pve_out_if.source  o_out
);

    localparam int PW = POSITION_WIDTH;
    localparam int TW = TIME_WIDTH;
    localparam int XW = 2*PW + 2;

    t_state r_state, n_state;

    logic [TW-1:0]        r_last_time;
    logic signed [PW-1:0] r_last [AXES];
    logic signed [PW-1:0] r_pos  [AXES];
    logic [PW:0]          r_mag  [AXES];
    logic                 r_neg  [AXES];
    logic [PW-1:0]        r_q    [AXES];
    logic [TW-1:0]        r_dt;
    logic [1:0]           r_idx;
    logic [2*PW-1:0]      r_prod;
    logic [XW-1:0]        r_sum;
    logic [PW-1:0]        r_speed_xy;
    logic [PW-1:0]        r_speed;
    logic                 r_out_valid;

    t_unit_ctl            unit_ctl;
    t_unit_stat           unit_stat;
    logic [XW-1:0]        unit_opnd;
    logic [PW-1:0]        unit_res;

    logic                 accept;
    logic                 load_out;
    logic signed [PW-1:0] in_pos  [AXES];
    logic signed [PW-1:0] in_org  [AXES];
    logic signed [PW-1:0] prev    [AXES];
    logic signed [PW:0]   delta   [AXES];
    logic [PW-1:0]        vel     [AXES];

    localparam logic [PW-1:0] VMAX = {1'b0, {(PW-1){1'b1}}};
    localparam logic [PW-1:0] VMIN = {1'b1, {(PW-1){1'b0}}};

    assign accept     = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);

    assign in_pos[0] = i_in.entity_present ? i_in.pos_x : '0;
    assign in_pos[1] = i_in.entity_present ? i_in.pos_y : '0;
    assign in_pos[2] = i_in.entity_present ? i_in.pos_z : '0;
    assign in_org[0] = i_in.origin_x;
    assign in_org[1] = i_in.origin_y;
    assign in_org[2] = i_in.origin_z;

    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            prev[a]  = (r_last_time == '0) ? in_org[a] : r_last[a];
            delta[a] = {in_pos[a][PW-1], in_pos[a]} - {prev[a][PW-1], prev[a]};
            if (r_neg[a]) begin
                vel[a] = (r_q[a] > VMIN) ? VMIN : (PW'(0) - r_q[a]);
            end else begin
                vel[a] = r_q[a][PW-1] ? VMAX : r_q[a];
            end
        end
    end

    pve_iter #(
        .PW (PW),
        .TW (TW)
    ) u_iter (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (unit_ctl),
        .i_operand (unit_opnd),
        .i_divisor (r_dt),
        .o_stat    (unit_stat),
        .o_result  (unit_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        unit_ctl  = '{start: 1'b0, mode: M_DIV};
        unit_opnd = r_sum;
        load_out  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept && !i_in.index_invalid && (i_in.now > r_last_time)) begin
                    n_state = S_DIV_GO;
                end
            end
            S_DIV_GO: begin
                unit_ctl  = '{start: 1'b1, mode: M_DIV};
                unit_opnd = {r_mag[r_idx], {(XW-PW-1){1'b0}}};
                n_state   = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (unit_stat.done) begin
                    n_state = (r_idx == 2'd2) ? S_MUL : S_DIV_GO;
                end
            end
            S_MUL: begin
                n_state = S_ADD;
            end
            S_ADD: begin
                n_state = (r_idx == 2'd0) ? S_MUL : S_SQ_GO;
            end
            S_SQ_GO: begin
                unit_ctl = '{start: 1'b1, mode: M_SQRT};
                n_state  = S_SQ_WAIT;
            end
            S_SQ_WAIT: begin
                if (unit_stat.done) begin
                    n_state = (r_idx == 2'd1) ? S_MUL : S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || o_out.ready) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_time <= '0;
            r_out_valid <= 1'b0;
            for (int a = 0; a < AXES; a++) begin
                r_last[a] <= '0;
            end
        end else begin
            if (accept && !i_in.index_invalid) begin
                r_last_time <= i_in.now;
                if (i_in.now > r_last_time) begin
                    for (int a = 0; a < AXES; a++) begin
                        r_last[a] <= in_pos[a];
                    end
                end
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_idx <= 2'd0;
                r_sum <= '0;
                r_dt  <= i_in.now - r_last_time;
                for (int a = 0; a < AXES; a++) begin
                    r_pos[a] <= in_pos[a];
                    r_neg[a] <= delta[a][PW];
                    r_mag[a] <= delta[a][PW] ? (PW+1)'(-delta[a]) : delta[a];
                end
            end
            S_DIV_WAIT: begin
                if (unit_stat.done) begin
                    r_q[r_idx] <= unit_res;
                    r_idx      <= (r_idx == 2'd2) ? 2'd0 : r_idx + 2'd1;
                end
            end
            S_MUL: begin
                r_prod <= (2*PW)'(r_q[r_idx]) * (2*PW)'(r_q[r_idx]);
            end
            S_ADD: begin
                r_sum <= r_sum + XW'(r_prod);
                if (r_idx == 2'd0) begin
                    r_idx <= 2'd1;
                end
            end
            S_SQ_WAIT: begin
                if (unit_stat.done) begin
                    if (r_idx == 2'd1) begin
                        r_speed_xy <= unit_res;
                        r_idx      <= 2'd2;
                    end else begin
                        r_speed    <= unit_res;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            o_out.out_x    <= r_pos[0];
            o_out.out_y    <= r_pos[1];
            o_out.out_z    <= r_pos[2];
            o_out.vel_x    <= vel[0];
            o_out.vel_y    <= vel[1];
            o_out.vel_z    <= vel[2];
            o_out.speed    <= r_speed;
            o_out.speed_xy <= r_speed_xy;
        end
    end

    assign o_out.valid = r_out_valid;

endmodule
